@@ hw/rtl/gated_multichannel_moving_average_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the moving-average core
// Shared shorthand for clocked implication checks with reset masking.
// ----------------------------------------------------------------------------
`ifndef GATED_MULTICHANNEL_MOVING_AVERAGE_CORE_ASSERT_SVH
`define GATED_MULTICHANNEL_MOVING_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication
`define GMMA_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define GMMA_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ hw/rtl/gmma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmma_pkg
// Widths, reset values, register codes and stage control type shared by the
// moving-average core.
// ----------------------------------------------------------------------------
package gmma_pkg;

   localparam int unsigned CHANNELS_DEF = 4;
   localparam int unsigned DEPTH_DEF    = 8;

   localparam int unsigned CHAN_W    = 2;
   localparam int unsigned RAW_W     = 16;
   localparam int unsigned DATA_W    = 10;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [DATA_W-1:0] RESET_FILL    = 10'd2;
   localparam logic [DATA_W-1:0] MIN_VALID_RST = 10'd2;
   localparam logic [DATA_W-1:0] MAX_VALID_RST = 10'd400;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_VALID = 1'b0,
      CSR_MAX_VALID = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic valid;        // stage holds a beat
      logic ch_ok;        // channel is below CHANNELS
      logic evict_valid;  // ring slot was written before, else reads as fill
   } stage_ctl_type;

endpackage

@@ hw/rtl/gmma_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmma_req_if
// Reading channel: one tagged raw distance per beat.
// ----------------------------------------------------------------------------
interface gmma_req_if;
   logic                       valid;
   logic                       ready;
   logic [gmma_pkg::CHAN_W-1:0] channel;
   logic [gmma_pkg::RAW_W-1:0]  raw_distance;

   modport source (output valid, output channel, output raw_distance, input ready);
   modport sink   (input valid, input channel, input raw_distance, output ready);
endinterface

@@ hw/rtl/gmma_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmma_rsp_if
// Result channel: one smoothed distance per beat.
// ----------------------------------------------------------------------------
interface gmma_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gmma_pkg::DATA_W-1:0] smoothed_distance;

   modport source (output valid, output smoothed_distance, input ready);
   modport sink   (input valid, input smoothed_distance, output ready);
endinterface

@@ hw/rtl/gmma_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmma_ring
// Per-channel history memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module gmma_ring #(
   parameter int unsigned CHANNELS = gmma_pkg::CHANNELS_DEF,
   parameter int unsigned DEPTH    = gmma_pkg::DEPTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              wr_en,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_ch,
   input  logic [$clog2(DEPTH)-1:0]                          wr_ptr,
   input  logic [gmma_pkg::DATA_W-1:0]                       wr_data,
   input  logic                                              rd_en,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_ch,
   input  logic [$clog2(DEPTH)-1:0]                          rd_ptr,
   output logic [gmma_pkg::DATA_W-1:0]                       rd_data
);
   import gmma_pkg::*;

   logic [DATA_W-1:0] ring_mem [CHANNELS][DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_ch][wr_ptr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_ch][rd_ptr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/gmma_issue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmma_issue
// Input stage: takes a reading, advances the channel's ring pointer, issues
// the ring read of the slot to evict and registers the beat.
// ----------------------------------------------------------------------------
module gmma_issue #(
   parameter int unsigned CHANNELS = gmma_pkg::CHANNELS_DEF,
   parameter int unsigned DEPTH    = gmma_pkg::DEPTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_valid,
   output logic                                              req_ready,
   input  logic [gmma_pkg::CHAN_W-1:0]                       req_channel,
   input  logic [gmma_pkg::RAW_W-1:0]                        req_raw,
   input  logic                                              s1_take,
   output gmma_pkg::stage_ctl_type                           s1_ctl,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] s1_ch,
   output logic [gmma_pkg::RAW_W-1:0]                        s1_raw,
   output logic [$clog2(DEPTH)-1:0]                          s1_ptr,
   output logic                                              rd_en,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_ch,
   output logic [$clog2(DEPTH)-1:0]                          rd_ptr
);
   import gmma_pkg::*;

   localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned PTR_W    = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0]    ptr_ff [CHANNELS];
   logic                wrap_ff [CHANNELS];
   stage_ctl_type       s1_ctl_ff;
   stage_ctl_type       s1_ctl_in;
   logic [CH_IDX_W-1:0] s1_ch_ff;
   logic [RAW_W-1:0]    s1_raw_ff;
   logic [PTR_W-1:0]    s1_ptr_ff;

   logic                accept;
   logic                ch_ok;
   logic [CH_IDX_W-1:0] ch_idx;
   logic [PTR_W-1:0]    cur_ptr;
   logic                ptr_last;
   logic [PTR_W-1:0]    ptr_in;

   assign req_ready = !s1_ctl_ff.valid || s1_take;
   assign accept    = req_valid && req_ready;
   assign ch_ok     = 32'(req_channel) < CHANNELS;
   assign ch_idx    = CH_IDX_W'(req_channel);
   assign cur_ptr   = ptr_ff[ch_idx];
   assign ptr_last  = (cur_ptr == PTR_LAST);
   assign ptr_in    = ptr_last ? '0 : cur_ptr + PTR_W'(1);

   always_comb begin
      s1_ctl_in.valid       = 1'b1;
      s1_ctl_in.ch_ok       = ch_ok;
      s1_ctl_in.evict_valid = ch_ok && wrap_ff[ch_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            ptr_ff[c]  <= '0;
            wrap_ff[c] <= 1'b0;
         end
         s1_ctl_ff <= '0;
      end else begin
         if (accept && ch_ok) begin
            ptr_ff[ch_idx] <= ptr_in;
            // once a ring has gone around, every slot holds a written value
            if (ptr_last) begin
               wrap_ff[ch_idx] <= 1'b1;
            end
         end
         if (accept) begin
            s1_ctl_ff <= s1_ctl_in;
         end else if (s1_take) begin
            s1_ctl_ff.valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff  <= ch_idx;
         s1_raw_ff <= req_raw;
         s1_ptr_ff <= cur_ptr;
      end
   end

   assign rd_en  = accept && ch_ok;
   assign rd_ch  = ch_idx;
   assign rd_ptr = cur_ptr;

   assign s1_ctl = s1_ctl_ff;
   assign s1_ch  = s1_ch_ff;
   assign s1_raw = s1_raw_ff;
   assign s1_ptr = s1_ptr_ff;

endmodule

@@ hw/rtl/gmma_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmma_accum
// Gate, hold, running-sum update and mean for the registered beat; owns the
// window registers and the result register.
// ----------------------------------------------------------------------------
module gmma_accum #(
   parameter int unsigned CHANNELS = gmma_pkg::CHANNELS_DEF,
   parameter int unsigned DEPTH    = gmma_pkg::DEPTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              csr_wr_en,
   input  logic [gmma_pkg::CSR_IDX_W-1:0]                    csr_index,
   input  logic [gmma_pkg::DATA_W-1:0]                       csr_wdata,
   input  gmma_pkg::stage_ctl_type                           s1_ctl,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] s1_ch,
   input  logic [gmma_pkg::RAW_W-1:0]                        s1_raw,
   input  logic [$clog2(DEPTH)-1:0]                          s1_ptr,
   input  logic [gmma_pkg::DATA_W-1:0]                       evicted,
   output logic                                              s1_take,
   output logic                                              wr_en,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_ch,
   output logic [$clog2(DEPTH)-1:0]                          wr_ptr,
   output logic [gmma_pkg::DATA_W-1:0]                       wr_data,
   output logic                                              rsp_valid,
   input  logic                                              rsp_ready,
   output logic [gmma_pkg::DATA_W-1:0]                       rsp_data
);
   import gmma_pkg::*;

   localparam int unsigned PTR_W       = $clog2(DEPTH);
   localparam int unsigned SUM_W       = DATA_W + PTR_W;
   localparam int unsigned RECIP_SHIFT = SUM_W + PTR_W;
   localparam int unsigned RECIP_W     = SUM_W + 1;
   localparam int unsigned PROD_W      = SUM_W + RECIP_W;
   // ceil(2^RECIP_SHIFT / DEPTH): exact floor quotient for any SUM_W-bit sum
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));
   localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(RESET_FILL) * SUM_W'(DEPTH);

   logic [DATA_W-1:0] min_valid_ff;
   logic [DATA_W-1:0] max_valid_ff;
   logic [DATA_W-1:0] held_ff [CHANNELS];
   logic [SUM_W-1:0]  sum_ff [CHANNELS];
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [DATA_W-1:0] rsp_data_in;

   logic              raw_ok;
   logic              update;
   logic [DATA_W-1:0] fresh;
   logic [DATA_W-1:0] evict;
   logic [SUM_W-1:0]  sum_in;
   logic [PROD_W-1:0] product;
   logic [DATA_W-1:0] mean;

   assign s1_take = s1_ctl.valid && (!rsp_valid_ff || rsp_ready);
   assign update  = s1_take && s1_ctl.ch_ok;

   // zero always passes; anything above the window, including >1023, is dropped
   assign raw_ok = (s1_raw == '0)
                || ((s1_raw >= RAW_W'(min_valid_ff)) && (s1_raw <= RAW_W'(max_valid_ff)));
   assign fresh   = raw_ok ? s1_raw[DATA_W-1:0] : held_ff[s1_ch];
   assign evict   = s1_ctl.evict_valid ? evicted : RESET_FILL;
   assign sum_in  = sum_ff[s1_ch] - SUM_W'(evict) + SUM_W'(fresh);
   assign product = PROD_W'(sum_in) * PROD_W'(RECIP);
   assign mean    = product[RECIP_SHIFT +: DATA_W];
   assign rsp_data_in = s1_ctl.ch_ok ? mean : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_valid_ff <= MIN_VALID_RST;
         max_valid_ff <= MAX_VALID_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_VALID: min_valid_ff <= csr_wdata;
            CSR_MAX_VALID: max_valid_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            held_ff[c] <= RESET_FILL;
            sum_ff[c]  <= SUM_RST;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (update) begin
            held_ff[s1_ch] <= fresh;
            sum_ff[s1_ch]  <= sum_in;
         end
         if (s1_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign wr_en   = update;
   assign wr_ch   = s1_ch;
   assign wr_ptr  = s1_ptr;
   assign wr_data = fresh;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/gated_multichannel_moving_average_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_multichannel_moving_average_core
// Per-channel gated DEPTH-tap moving average of distance readings.
// ----------------------------------------------------------------------------
// Each accepted reading gives exactly one result, and a new reading is
// accepted every cycle as long as results drain. A reading taken at one clock
// edge enters the stage register, and unless a stalled result holds the stage,
// its result is loaded into the result register at the next edge. The stage
// register is there because the ring memory has a registered read port: the
// ring is read at acceptance, and the evicted value is used in the stage
// cycle together with the channel's held value and running sum. A stalled
// result holds the stage, and a held stage holds off the input. A reading
// passes the gate when it is zero or inside [min_valid, max_valid]. Otherwise
// the channel repeats its last held value. Rings, held values and sums start
// at the fill value 2 (sum 2*DEPTH) without a clearing pass: a per-channel
// wrap flag stands in for ring slots not yet written. A channel number at or
// above CHANNELS returns 0 and leaves all state untouched.
// ----------------------------------------------------------------------------
module gated_multichannel_moving_average_core #(
   parameter int unsigned CHANNELS = gmma_pkg::CHANNELS_DEF,
   parameter int unsigned DEPTH    = gmma_pkg::DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   gmma_req_if.sink                       req_bus,
   gmma_rsp_if.source                     rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [gmma_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmma_pkg::DATA_W-1:0]    csr_wdata
);
   import gmma_pkg::*;

   `include "gated_multichannel_moving_average_core_assert.svh"

   localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned PTR_W    = $clog2(DEPTH);

   stage_ctl_type       s1_ctl;
   logic [CH_IDX_W-1:0] s1_ch;
   logic [RAW_W-1:0]    s1_raw;
   logic [PTR_W-1:0]    s1_ptr;
   logic                s1_take;
   logic                rd_en;
   logic [CH_IDX_W-1:0] rd_ch;
   logic [PTR_W-1:0]    rd_ptr;
   logic [DATA_W-1:0]   rd_data;
   logic                wr_en;
   logic [CH_IDX_W-1:0] wr_ch;
   logic [PTR_W-1:0]    wr_ptr;
   logic [DATA_W-1:0]   wr_data;

   gmma_issue #(
      .CHANNELS (CHANNELS),
      .DEPTH    (DEPTH)
   ) u_issue (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_channel (req_bus.channel),
      .req_raw     (req_bus.raw_distance),
      .s1_take     (s1_take),
      .s1_ctl      (s1_ctl),
      .s1_ch       (s1_ch),
      .s1_raw      (s1_raw),
      .s1_ptr      (s1_ptr),
      .rd_en       (rd_en),
      .rd_ch       (rd_ch),
      .rd_ptr      (rd_ptr)
   );

   gmma_ring #(
      .CHANNELS (CHANNELS),
      .DEPTH    (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_ch   (wr_ch),
      .wr_ptr  (wr_ptr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_ch   (rd_ch),
      .rd_ptr  (rd_ptr),
      .rd_data (rd_data)
   );

   gmma_accum #(
      .CHANNELS (CHANNELS),
      .DEPTH    (DEPTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .s1_ctl    (s1_ctl),
      .s1_ch     (s1_ch),
      .s1_raw    (s1_raw),
      .s1_ptr    (s1_ptr),
      .evicted   (rd_data),
      .s1_take   (s1_take),
      .wr_en     (wr_en),
      .wr_ch     (wr_ch),
      .wr_ptr    (wr_ptr),
      .wr_data   (wr_data),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_bus.smoothed_distance)
   );

   `GMMA_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_bus.valid && req_bus.ready, s1_ctl.valid, "accepted beat did not reach the stage register")
   `GMMA_ASSERT_NOW(a_stall_blocks_input, clock, reset, s1_ctl.valid && !s1_take, !req_bus.ready, "input ready while the stage is stalled")
   `GMMA_ASSERT_NOW(a_ring_write_in_range, clock, reset, wr_en, s1_ctl.valid && s1_ctl.ch_ok, "ring written for an absent or out-of-range beat")
   `GMMA_ASSERT_NEXT(a_bad_channel_zero, clock, reset, s1_take && !s1_ctl.ch_ok, rsp_bus.valid && (rsp_bus.smoothed_distance == '0), "out-of-range channel gave a nonzero result")

endmodule
